// ===== hdl/hst_pkg.sv =====
// Shared types, codes and field widths for the handle slot table.
`default_nettype none

package hst_pkg;

    // Field widths of the request and result transfers.
    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 6;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 2;
    localparam int FREE_W   = 7;

    // Request codes.
    localparam logic [ACTION_W-1:0] ACT_ADD = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SET = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_GET = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NOP = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_ZERO  = 2'd3;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_FIND
    } fsm_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic finish;
    } hst_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/handle_slot_table.sv =====
// An accepted request passes through the execute cycle (store read-modify-write) and the
// lowest-free encode cycle, and its result is registered once the output is free. While
// results are taken, a new request can be accepted in the previous request's encode cycle.
// Reset clears all occupancy flags, sets the free count to SLOT_COUNT and the
// lowest free slot to zero at once; store words are not cleared, free slots read as zero.
`default_nettype none

module handle_slot_table #(
    parameter int SLOT_COUNT  = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [hst_pkg::ACTION_W-1:0]  action,
    input  wire logic [hst_pkg::INDEX_W-1:0]   slot_index,
    input  wire logic [hst_pkg::HANDLE_W-1:0]  handle_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [hst_pkg::STATUS_W-1:0]  status,
    output logic      [hst_pkg::INDEX_W-1:0]   granted_index,
    output logic      [hst_pkg::HANDLE_W-1:0]  read_value,
    output logic      [hst_pkg::FREE_W-1:0]    free_slots
);

    hst_pkg::hst_cmd_t cmd;

    hst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    hst_datapath #(
        .SLOT_COUNT  (SLOT_COUNT),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .action        (action),
        .slot_index    (slot_index),
        .handle_value  (handle_value),
        .status        (status),
        .granted_index (granted_index),
        .read_value    (read_value),
        .free_slots    (free_slots)
    );

endmodule

`default_nettype wire

// ===== hdl/hst_ctrl.sv =====
// Controller state machine that sequences each request through execute and encode cycles.
`default_nettype none

module hst_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output hst_pkg::hst_cmd_t      cmd
);

    hst_pkg::fsm_state_t state_reg;
    hst_pkg::fsm_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hst_pkg::FSM_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hst_pkg::FSM_IDLE:
            begin
                if (in_valid)
                    state_next = hst_pkg::FSM_EXEC;
            end
            hst_pkg::FSM_EXEC:
            begin
                state_next = hst_pkg::FSM_FIND;
            end
            hst_pkg::FSM_FIND:
            begin
                // The result leaves for the output register; a waiting request
                // can start right behind it.
                if (out_free)
                    state_next = in_valid ? hst_pkg::FSM_EXEC : hst_pkg::FSM_IDLE;
            end
            default:
            begin
                state_next = hst_pkg::FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.exec   = 1'b0;
        cmd.finish = 1'b0;
        unique case (state_reg)
            hst_pkg::FSM_IDLE:
            begin
                in_ready = 1'b1;
            end
            hst_pkg::FSM_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            hst_pkg::FSM_FIND:
            begin
                in_ready   = out_free;
                cmd.finish = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        cmd.capture    = in_valid && in_ready;
        out_valid_next = cmd.finish ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    assign out_valid = out_valid_reg;

    a_exec_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == hst_pkg::FSM_EXEC)
        else $error("accepted request did not enter the execute cycle");

    a_find_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> state_reg == hst_pkg::FSM_FIND)
        else $error("execute cycle not followed by encode cycle");

    a_finish_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending result");

endmodule

`default_nettype wire

// ===== hdl/hst_datapath.sv =====
// Datapath with the slot store, occupancy flags, free count and result registers.
`default_nettype none

module hst_datapath #(
    parameter int SLOT_COUNT  = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire hst_pkg::hst_cmd_t               cmd,
    input  wire logic [hst_pkg::ACTION_W-1:0]    action,
    input  wire logic [hst_pkg::INDEX_W-1:0]     slot_index,
    input  wire logic [hst_pkg::HANDLE_W-1:0]    handle_value,
    output logic      [hst_pkg::STATUS_W-1:0]    status,
    output logic      [hst_pkg::INDEX_W-1:0]     granted_index,
    output logic      [hst_pkg::HANDLE_W-1:0]    read_value,
    output logic      [hst_pkg::FREE_W-1:0]      free_slots
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int AW    = (IDX_W > hst_pkg::INDEX_W) ? IDX_W : hst_pkg::INDEX_W;
    localparam int CW    = ((CNT_W > hst_pkg::INDEX_W) ? CNT_W : hst_pkg::INDEX_W) + 1;
    localparam int XW    = (VALUE_WIDTH > hst_pkg::HANDLE_W) ? VALUE_WIDTH : hst_pkg::HANDLE_W;

    // Captured request.
    logic [hst_pkg::ACTION_W-1:0] act_reg;
    logic [hst_pkg::INDEX_W-1:0]  idx_reg;
    logic [VALUE_WIDTH-1:0]       val_reg;

    // Table state.
    logic [VALUE_WIDTH-1:0] mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]  occ_reg;
    logic [CNT_W-1:0]       free_reg;
    logic [CNT_W-1:0]       free_next;
    logic [CNT_W-1:0]       lowest_reg;
    logic [CNT_W-1:0]       first_free;
    logic [VALUE_WIDTH-1:0] rdata_reg;

    // Execute-cycle results waiting for the encode cycle.
    logic [hst_pkg::STATUS_W-1:0] st_reg;
    logic [hst_pkg::STATUS_W-1:0] st_next;
    logic [hst_pkg::INDEX_W-1:0]  grant_reg;
    logic [hst_pkg::INDEX_W-1:0]  grant_next;
    logic                         rd_ok_reg;
    logic                         rd_ok_next;

    // Output registers.
    logic [hst_pkg::STATUS_W-1:0] status_reg;
    logic [hst_pkg::INDEX_W-1:0]  granted_reg;
    logic [hst_pkg::HANDLE_W-1:0] read_reg;
    logic [hst_pkg::FREE_W-1:0]   free_out_reg;

    logic [XW-1:0]          hv_ext;
    logic [XW-1:0]          rd_ext;
    logic [AW-1:0]          idx_ext;
    logic [IDX_W-1:0]       slot_sel;
    logic [IDX_W-1:0]       lowest_sel;
    logic                   in_range;
    logic                   was_occ;
    logic                   val_zero;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_addr;
    logic                   occ_we;
    logic                   occ_val;

    assign hv_ext     = XW'(handle_value);
    assign rd_ext     = XW'(rdata_reg);
    assign idx_ext    = AW'(idx_reg);
    assign slot_sel   = idx_ext[IDX_W-1:0];
    assign lowest_sel = lowest_reg[IDX_W-1:0];
    assign in_range   = CW'(idx_reg) < CW'(SLOT_COUNT);
    assign was_occ    = occ_reg[slot_sel];
    assign val_zero   = (val_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= action;
            idx_reg <= slot_index;
            val_reg <= hv_ext[VALUE_WIDTH-1:0];
        end
    end

    always_comb
    begin
        st_next    = hst_pkg::STAT_OK;
        grant_next = '0;
        rd_ok_next = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = slot_sel;
        occ_we     = 1'b0;
        occ_val    = 1'b0;
        free_next  = free_reg;
        unique case (act_reg)
            hst_pkg::ACT_ADD:
            begin
                if (val_zero)
                    st_next = hst_pkg::STAT_ZERO;
                else if (free_reg == '0)
                    st_next = hst_pkg::STAT_FULL;
                else
                begin
                    mem_we     = 1'b1;
                    mem_addr   = lowest_sel;
                    occ_we     = 1'b1;
                    occ_val    = 1'b1;
                    free_next  = free_reg - 1'b1;
                    grant_next = hst_pkg::INDEX_W'(lowest_reg);
                end
            end
            hst_pkg::ACT_SET:
            begin
                if (!in_range)
                    st_next = hst_pkg::STAT_RANGE;
                else
                begin
                    mem_we  = 1'b1;
                    occ_we  = 1'b1;
                    occ_val = !val_zero;
                    if (!was_occ && !val_zero)
                        free_next = free_reg - 1'b1;
                    else if (was_occ && val_zero)
                        free_next = free_reg + 1'b1;
                end
            end
            hst_pkg::ACT_GET:
            begin
                if (!in_range)
                    st_next = hst_pkg::STAT_RANGE;
                else
                    rd_ok_next = was_occ;
            end
            default:
            begin
                st_next = hst_pkg::STAT_OK;
            end
        endcase
    end

    // Store write and registered read; a free slot reads as zero through its flag.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && mem_we)
            mem[mem_addr] <= val_reg;
        if (cmd.exec)
            rdata_reg <= mem[slot_sel];
    end

    // The lowest free slot is always the first clear occupancy flag.
    always_comb
    begin
        first_free = CNT_W'(SLOT_COUNT);
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!occ_reg[i])
                first_free = CNT_W'(i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg    <= '0;
            free_reg   <= CNT_W'(SLOT_COUNT);
            lowest_reg <= '0;
        end
        else
        begin
            if (cmd.exec)
            begin
                free_reg <= free_next;
                if (occ_we)
                    occ_reg[mem_addr] <= occ_val;
            end
            if (!cmd.exec)
                lowest_reg <= first_free;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            st_reg    <= st_next;
            grant_reg <= grant_next;
            rd_ok_reg <= rd_ok_next;
        end
        if (cmd.finish)
        begin
            status_reg   <= st_reg;
            granted_reg  <= grant_reg;
            read_reg     <= rd_ok_reg ? rd_ext[hst_pkg::HANDLE_W-1:0] : '0;
            free_out_reg <= hst_pkg::FREE_W'(free_reg);
        end
    end

    assign status        = status_reg;
    assign granted_index = granted_reg;
    assign read_value    = read_reg;
    assign free_slots    = free_out_reg;

    a_count_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(occ_reg) + int'(free_reg)) == SLOT_COUNT)
        else $error("free count disagrees with occupancy flags");

    a_lowest_is_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> (free_reg == '0) || !occ_reg[lowest_sel])
        else $error("lowest free slot points at an occupied slot");

    a_full_means_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> ((free_reg == '0) == (lowest_reg == CNT_W'(SLOT_COUNT))))
        else $error("full flag and lowest free slot disagree");

endmodule

`default_nettype wire

// ===== tb/tb_handle_slot_table.sv =====
// Self-checking testbench for the handle slot table: add, set, get and spare-code traffic against a mirror.
`default_nettype none

module tb_handle_slot_table;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_GAP     = 60;

    typedef struct {
        logic [hst_pkg::STATUS_W-1:0] status;
        logic [hst_pkg::INDEX_W-1:0]  granted;
        logic [hst_pkg::HANDLE_W-1:0] read_data;
        logic [hst_pkg::FREE_W-1:0]   free_after;
    } table_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [hst_pkg::ACTION_W-1:0] action = hst_pkg::ACT_ADD;
    logic [hst_pkg::INDEX_W-1:0]  slot_index = '0;
    logic [hst_pkg::HANDLE_W-1:0] handle_value = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [hst_pkg::STATUS_W-1:0] status;
    logic [hst_pkg::INDEX_W-1:0]  granted_index;
    logic [hst_pkg::HANDLE_W-1:0] read_value;
    logic [hst_pkg::FREE_W-1:0]   free_slots;

    // Mirror of the table contents and its bookkeeping.
    logic [hst_pkg::HANDLE_W-1:0] slot_mirror [SLOTS];
    int                           mirror_lowest;
    int                           mirror_free;

    table_result_t       pending_results [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;
    int cycle_count    = 0;
    int mismatches     = 0;
    int results_seen   = 0;
    int requests_sent  = 0;
    int action_sent [4];
    int status_seen [4];

    handle_slot_table #(
        .SLOT_COUNT  (SLOTS),
        .VALUE_WIDTH (hst_pkg::HANDLE_W)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .slot_index    (slot_index),
        .handle_value  (handle_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .granted_index (granted_index),
        .read_value    (read_value),
        .free_slots    (free_slots)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int next_free_from(int start);
        for (int i = start; i < SLOTS; i++)
        begin
            if (slot_mirror[i] == '0)
                return i;
        end
        return SLOTS;
    endfunction

    function automatic table_result_t predict_request(logic [hst_pkg::ACTION_W-1:0] act,
                                                      logic [hst_pkg::INDEX_W-1:0] idx,
                                                      logic [hst_pkg::HANDLE_W-1:0] val);
        table_result_t r;
        int            slot;
        logic          was_free;
        r.status    = hst_pkg::STAT_OK;
        r.granted   = '0;
        r.read_data = '0;
        slot        = int'(idx);
        case (act)
            hst_pkg::ACT_ADD:
            begin
                if (val == '0)
                    r.status = hst_pkg::STAT_ZERO;
                else if (mirror_free == 0 || mirror_lowest >= SLOTS)
                    r.status = hst_pkg::STAT_FULL;
                else
                begin
                    slot_mirror[mirror_lowest] = val;
                    mirror_free--;
                    r.granted     = hst_pkg::INDEX_W'(mirror_lowest);
                    mirror_lowest = next_free_from(mirror_lowest + 1);
                end
            end
            hst_pkg::ACT_SET:
            begin
                if (slot >= SLOTS)
                    r.status = hst_pkg::STAT_RANGE;
                else
                begin
                    was_free          = (slot_mirror[slot] == '0);
                    slot_mirror[slot] = val;
                    if (was_free && val != '0)
                    begin
                        mirror_free--;
                        if (slot == mirror_lowest)
                            mirror_lowest = next_free_from(slot + 1);
                    end
                    else if (!was_free && val == '0)
                    begin
                        mirror_free++;
                        if (slot < mirror_lowest)
                            mirror_lowest = slot;
                    end
                end
            end
            hst_pkg::ACT_GET:
            begin
                if (slot >= SLOTS)
                    r.status = hst_pkg::STAT_RANGE;
                else
                    r.read_data = slot_mirror[slot];
            end
            default:
            begin
                // The spare action code changes nothing.
            end
        endcase
        r.free_after = hst_pkg::FREE_W'(mirror_free);
        return r;
    endfunction

    // Sender: an optional idle gap, then hold the request until it transfers.
    task automatic send_request(input logic [hst_pkg::ACTION_W-1:0] act,
                                input logic [hst_pkg::INDEX_W-1:0] idx,
                                input logic [hst_pkg::HANDLE_W-1:0] val);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        slot_index   <= idx;
        handle_value <= val;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(predict_request(act, idx, val));
        requests_sent++;
        action_sent[act]++;
    endtask

    // Drop valid and pause until every outstanding result has been taken.
    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic check_result();
        table_result_t want;
        results_seen++;
        status_seen[status]++;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("result with none expected: status %0d index %0d",
                                      status, granted_index));
            return;
        end
        want = pending_results.pop_front();
        if (status !== want.status)
            report_mismatch($sformatf("status expected %0d got %0d", want.status, status));
        if (granted_index !== want.granted)
            report_mismatch($sformatf("granted_index expected %0d got %0d",
                                      want.granted, granted_index));
        if (read_value !== want.read_data)
            report_mismatch($sformatf("read_value expected %h got %h",
                                      want.read_data, read_value));
        if (free_slots !== want.free_after)
            report_mismatch($sformatf("free_slots expected %0d got %0d",
                                      want.free_after, free_slots));
    endtask

    // Receiver: checks each result transfer and decides ready for the next edge.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            check_result();
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [hst_pkg::HANDLE_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return '1;
            1:       return hst_pkg::HANDLE_W'(1) << $urandom_range(hst_pkg::HANDLE_W - 1);
            2:       return hst_pkg::HANDLE_W'($urandom_range(255));
            default: return $urandom;
        endcase
    endfunction

    task automatic random_request(input int add_pct);
        int                           pick;
        logic [hst_pkg::HANDLE_W-1:0] val;
        pick = $urandom_range(99);
        val  = pick_value();
        if (pick < add_pct)
        begin
            if ($urandom_range(19) == 0)
                val = '0;
            send_request(hst_pkg::ACT_ADD, hst_pkg::INDEX_W'($urandom), val);
        end
        else if (pick < add_pct + 25)
        begin
            // About half the sets write zero, which releases the slot if it was occupied.
            if ($urandom_range(1) == 0)
                val = '0;
            send_request(hst_pkg::ACT_SET, hst_pkg::INDEX_W'($urandom), val);
        end
        else if (pick < 95)
            send_request(hst_pkg::ACT_GET, hst_pkg::INDEX_W'($urandom), val);
        else
            send_request(hst_pkg::ACT_NOP, hst_pkg::INDEX_W'($urandom), val);
    endtask

    task automatic run_random_requests(input int count, input int add_pct);
        repeat (count) random_request(add_pct);
        wait_all_results();
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 30;
        send_request(hst_pkg::ACT_GET, 6'd0,  32'h0);
        send_request(hst_pkg::ACT_ADD, 6'd7,  32'h0);
        send_request(hst_pkg::ACT_ADD, 6'd63, 32'hFFFF_FFFF);
        send_request(hst_pkg::ACT_ADD, 6'd0,  32'h0000_0001);
        send_request(hst_pkg::ACT_SET, 6'd63, 32'hFFFF_FFFF);
        send_request(hst_pkg::ACT_GET, 6'd63, 32'h0);
        // Filling the lowest free slot moves the pointer upward.
        send_request(hst_pkg::ACT_SET, 6'd2,  32'hA5A5_A5A5);
        send_request(hst_pkg::ACT_SET, 6'd2,  32'h5A5A_5A5A);
        send_request(hst_pkg::ACT_SET, 6'd5,  32'h0);
        // Freeing a slot below the pointer pulls it back down.
        send_request(hst_pkg::ACT_SET, 6'd1,  32'h0);
        send_request(hst_pkg::ACT_ADD, 6'd0,  32'h8000_0000);
        send_request(hst_pkg::ACT_GET, 6'd2,  32'hFFFF_FFFF);
        send_request(hst_pkg::ACT_NOP, 6'd63, 32'hFFFF_FFFF);
        send_request(hst_pkg::ACT_SET, 6'd0,  32'h0);
        send_request(hst_pkg::ACT_GET, 6'd0,  32'h0);
        send_request(hst_pkg::ACT_ADD, 6'd42, 32'h7FFF_FFFF);
        send_request(hst_pkg::ACT_GET, 6'd1,  32'h0);
        send_request(hst_pkg::ACT_SET, 6'd63, 32'h0);
        send_request(hst_pkg::ACT_GET, 6'd63, 32'h0);
        send_request(hst_pkg::ACT_NOP, 6'd0,  32'h0);
        wait_all_results();
    endtask

    task automatic test_full_table();
        logic [hst_pkg::HANDLE_W-1:0] val;
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        while (mirror_free != 0)
        begin
            val = pick_value();
            if (val == '0)
                val = 32'h1;
            send_request(hst_pkg::ACT_ADD, hst_pkg::INDEX_W'($urandom), val);
        end
        send_request(hst_pkg::ACT_ADD, 6'd0, 32'h1234_5678);
        send_request(hst_pkg::ACT_ADD, 6'd0, 32'h0);
        send_request(hst_pkg::ACT_SET, 6'd20, 32'hDEAD_BEEF);
        send_request(hst_pkg::ACT_GET, 6'd20, 32'h0);
        send_request(hst_pkg::ACT_SET, 6'd63, 32'h0);
        send_request(hst_pkg::ACT_SET, 6'd10, 32'h0);
        send_request(hst_pkg::ACT_ADD, 6'd0, 32'hCAFE_0001);
        send_request(hst_pkg::ACT_ADD, 6'd0, 32'hCAFE_0002);
        send_request(hst_pkg::ACT_ADD, 6'd0, 32'hCAFE_0003);
        send_request(hst_pkg::ACT_GET, 6'd63, 32'h0);
        // Release a good share of the table so later traffic sees every fill level.
        repeat (40) send_request(hst_pkg::ACT_SET, hst_pkg::INDEX_W'($urandom), 32'h0);
        wait_all_results();
    endtask

    task automatic test_no_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_requests(130, 45);
    endtask

    task automatic test_sender_idle();
        send_idle_pct  = 82;
        recv_stall_pct = 0;
        run_random_requests(100, 30);
    endtask

    task automatic test_receiver_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 82;
        run_random_requests(100, 55);
    endtask

    task automatic test_both_idle();
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        run_random_requests(130, 40);
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // The receiver holds off while requests keep coming, so the input stalls.
        hold_request = 200;
        repeat (30) random_request(40);
        wait_all_results();
    endtask

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
            slot_mirror[i] = '0;
        mirror_lowest = 0;
        mirror_free   = SLOTS;
        for (int i = 0; i < 4; i++)
        begin
            action_sent[i] = 0;
            status_seen[i] = 0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_table();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_backpressure();

        wait_all_results();
        repeat (10) @(posedge clk);

        $display("%0d requests (add %0d, set %0d, get %0d, spare code %0d), %0d results checked",
                 requests_sent, action_sent[hst_pkg::ACT_ADD],
                 action_sent[hst_pkg::ACT_SET], action_sent[hst_pkg::ACT_GET],
                 action_sent[hst_pkg::ACT_NOP], results_seen);
        $display("statuses: ok %0d, full %0d, zero value %0d; %0d mismatches",
                 status_seen[hst_pkg::STAT_OK], status_seen[hst_pkg::STAT_FULL],
                 status_seen[hst_pkg::STAT_ZERO], mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
